/* design/tsnc_pkg.sv */
// Shared types and constants for the timestamp history restamping block.
// Used by tsnc_cell and timestamp_history_nearest_correction.

package tsnc_pkg;

    // default number of stored time pairs
    localparam int HISTORY_DEPTH_DEF = 128;

    // register reset values
    localparam logic [31:0] GAP_TOL_RESET = 32'd6000000;
    localparam logic        GAP_EN_RESET  = 1'b1;

    typedef logic [63:0] time_t;

    typedef enum logic {
        OP_RECORD  = 1'b0,
        OP_CORRECT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_GAP   = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_GAP_TOL = 1'b0,
        REG_GAP_EN  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic  valid;
        logic  found;
        time_t measure;
        time_t best_dist;
        time_t best_offset;
        time_t best_capture;
    } token_t;

endpackage

/* design/tsnc_cell.sv */
// One history cell: holds a (sensor, capture) pair that shifts to the next
// cell on a record, and updates the passing search token. Uses tsnc_pkg.

module tsnc_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  tsnc_pkg::time_t     sensor_in,
    input  tsnc_pkg::time_t     capture_in,
    input  logic [CNT_W-1:0]    hist_count,
    input  tsnc_pkg::token_t    tok_in,
    output tsnc_pkg::time_t     sensor_out,
    output tsnc_pkg::time_t     capture_out,
    output tsnc_pkg::token_t    tok_out
);
    import tsnc_pkg::*;

    time_t  sensor_reg;
    time_t  capture_reg;
    token_t tok_reg;
    token_t tok_next;
    time_t  diff_ms;
    time_t  diff_sm;
    time_t  pair_dist;
    logic   in_use;
    logic   take;

    // pair storage, shifts one place toward the old end on a record
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sensor_reg  <= sensor_in;
            capture_reg <= capture_in;
        end
    end

    // distance of this pair to the measurement time
    always_comb begin
        diff_ms   = tok_in.measure - sensor_reg;
        diff_sm   = sensor_reg - tok_in.measure;
        pair_dist = (tok_in.measure >= sensor_reg) ? diff_ms : diff_sm;
        in_use    = tok_in.valid && (hist_count > CNT_W'(IDX));
        take      = in_use && (!tok_in.found || (pair_dist < tok_in.best_dist));
        tok_next  = tok_in;
        tok_next.found = tok_in.found || in_use;
        if (take) begin
            tok_next.best_dist    = pair_dist;
            tok_next.best_offset  = diff_ms;
            tok_next.best_capture = capture_reg;
        end
    end

    // token register, valid cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.found        <= tok_next.found;
        tok_reg.measure      <= tok_next.measure;
        tok_reg.best_dist    <= tok_next.best_dist;
        tok_reg.best_offset  <= tok_next.best_offset;
        tok_reg.best_capture <= tok_next.best_capture;
    end

    assign sensor_out  = sensor_reg;
    assign capture_out = capture_reg;
    assign tok_out     = tok_reg;

endmodule

/* design/timestamp_history_nearest_correction.sv */
// Top level of the timestamp history restamping block: cell chain, control
// and register port. Depends on tsnc_pkg and tsnc_cell.
//
// Usage: the s_ channel takes one item per transfer. A record item
// (s_operation 0) pushes its sensor/capture pair into the newest cell, the
// whole row shifting by one and the oldest pair dropping out when full; its
// result carries the capture time and a gap flag. A correct item (s_operation
// 1) sends a search token down the row of HISTORY_DEPTH cells, one cell per
// cycle; the token keeps the nearest pair seen so far, newest winning ties,
// and the final add gives capture + (measure - sensor).
// A record item or a correct item on an empty history goes from ST_IDLE
// to ST_DONE; a search waits in ST_SEARCH while the token walks the cell
// chain. From ST_DONE the result moves into the m_ register. One item is
// worked on at a time: s_ready is high only in ST_IDLE, so the next is
// taken once the result has left ST_DONE. The m_ channel is an output
// register: a finished result waits there while the next item is taken
// and worked on; a held m_ready stalls the block once a second is ready.
// Reset empties the history, clears the previous sensor time and loads the
// register defaults (gap tolerance 6 ms, gap check on). No clearing pass.
// Registers (APB, byte address): 0 gap tolerance in ns, 4 gap check enable.

module timestamp_history_nearest_correction #(
    parameter int HISTORY_DEPTH = tsnc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  tsnc_pkg::time_t     s_sensor_time,
    input  tsnc_pkg::time_t     s_capture_time,
    input  tsnc_pkg::time_t     s_measure_time,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output tsnc_pkg::time_t     m_corrected_time,
    output logic [1:0]          m_status,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tsnc_pkg::*;

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    // configuration registers
    logic [31:0] gap_tol_reg;
    logic        gap_en_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    // history control
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    time_t            last_sensor_reg;
    logic             have_last_reg;

    // control and result registers
    state_t  state_reg;
    state_t  state_next;
    time_t   pend_time_reg;
    time_t   pend_time_next;
    status_t pend_status_reg;
    status_t pend_status_next;
    time_t   out_time_reg;
    time_t   out_time_next;
    status_t out_status_reg;
    status_t out_status_next;
    logic    out_valid_reg;
    logic    out_valid_next;

    logic    in_xfer;
    logic    is_record;
    logic    shift_en;
    time_t   gap_diff;
    logic    gap_hit;

    // cell row wiring
    time_t  sens_q [HISTORY_DEPTH];
    time_t  capt_q [HISTORY_DEPTH];
    token_t tok    [HISTORY_DEPTH+1];

    // register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_tol_reg <= GAP_TOL_RESET;
            gap_en_reg  <= GAP_EN_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_GAP_TOL: gap_tol_reg <= pwdata;
                REG_GAP_EN:  gap_en_reg  <= pwdata[0];
                default:     gap_en_reg  <= gap_en_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_GAP_TOL: prdata = gap_tol_reg;
            REG_GAP_EN:  prdata = {31'b0, gap_en_reg};
            default:     prdata = '0;
        endcase
    end

    // input transfer decode
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign is_record = (op_t'(s_operation) == OP_RECORD);
    assign shift_en  = in_xfer && is_record;

    // forward gap since the previous sensor time
    assign gap_diff = s_sensor_time - last_sensor_reg;
    assign gap_hit  = gap_en_reg && have_last_reg && !gap_diff[63]
                      && (gap_diff > {32'b0, gap_tol_reg});

    // fill count saturates at the depth
    always_comb begin
        count_next = count_reg;
        if (shift_en && (count_reg != CNT_W'(HISTORY_DEPTH))) begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            last_sensor_reg <= '0;
            have_last_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (shift_en) begin
                last_sensor_reg <= s_sensor_time;
                have_last_reg   <= 1'b1;
            end
        end
    end

    // search token enters the newest cell
    always_comb begin
        tok[0]              = '0;
        tok[0].valid        = in_xfer && !is_record && (count_reg != '0);
        tok[0].measure      = s_measure_time;
    end

    // row of history cells, newest at cell 0
    for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            tsnc_cell #(
                .IDX   (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .shift_en    (shift_en),
                .sensor_in   (s_sensor_time),
                .capture_in  (s_capture_time),
                .hist_count  (count_reg),
                .tok_in      (tok[i]),
                .sensor_out  (sens_q[i]),
                .capture_out (capt_q[i]),
                .tok_out     (tok[i+1])
            );
        end else begin : g_body
            tsnc_cell #(
                .IDX   (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .shift_en    (shift_en),
                .sensor_in   (sens_q[i-1]),
                .capture_in  (capt_q[i-1]),
                .hist_count  (count_reg),
                .tok_in      (tok[i]),
                .sensor_out  (sens_q[i]),
                .capture_out (capt_q[i]),
                .tok_out     (tok[i+1])
            );
        end
    end

    // control state machine: next state and result staging
    always_comb begin
        state_next       = state_reg;
        pend_time_next   = pend_time_reg;
        pend_status_next = pend_status_reg;
        out_time_next    = out_time_reg;
        out_status_next  = out_status_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (is_record) begin
                        pend_time_next   = s_capture_time;
                        pend_status_next = gap_hit ? STATUS_GAP : STATUS_OK;
                        state_next       = ST_DONE;
                    end else if (count_reg == '0) begin
                        pend_time_next   = '0;
                        pend_status_next = STATUS_EMPTY;
                        state_next       = ST_DONE;
                    end else begin
                        state_next       = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (tok[HISTORY_DEPTH].valid) begin
                    pend_time_next   = tok[HISTORY_DEPTH].best_capture
                                       + tok[HISTORY_DEPTH].best_offset;
                    pend_status_next = STATUS_OK;
                    state_next       = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_time_next   = pend_time_reg;
                    out_status_next = pend_status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        pend_time_reg   <= pend_time_next;
        pend_status_reg <= pend_status_next;
        out_time_reg    <= out_time_next;
        out_status_reg  <= out_status_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_corrected_time = out_time_reg;
    assign m_status         = out_status_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("history count above depth");

    a_token_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[HISTORY_DEPTH].valid |-> (state_reg == ST_SEARCH))
        else $error("search token left the row outside a search");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && !is_record && (count_reg == '0)) |=>
        (pend_status_reg == STATUS_EMPTY && state_reg == ST_DONE))
        else $error("empty history not flagged");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (shift_en && (count_reg != CNT_W'(HISTORY_DEPTH))) |=>
        (count_reg == $past(count_reg) + 1'b1))
        else $error("record did not grow the history");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_time_reg)))
        else $error("stalled result changed");

endmodule
